// ===== src/hmsc_pkg.sv =====
// Package with the shared types, constants and key table of the time-of-day clock.
package hmsc_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_HOUR_DIGIT = 3'd1,
    OP_MS_DIGIT   = 3'd2,
    OP_SET_HOURS  = 3'd3,
    OP_SET_MIN    = 3'd4,
    OP_SET_SEC    = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  localparam logic [5:0] HOURS_RESET   = 6'd19;
  localparam logic [5:0] MINUTES_RESET = 6'd10;
  localparam logic [5:0] SECONDS_RESET = 6'd22;
  localparam logic [5:0] LAST_SEC_MIN  = 6'd59;
  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_FULL   = 2'd2
  } pos_t;

  typedef struct packed {
    logic [5:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       key_accepted;
    logic       entry_complete;
  } res_t;

  function automatic logic [3:0] key_digit(input logic [3:0] key);
    logic [3:0] d;
    case (key)
      4'd0:    d = 4'd1;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd3;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd5;
      4'd6:    d = 4'd6;
      4'd8:    d = 4'd7;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd9;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/hms_clock_with_digit_entry.sv =====
// Top level of the time-of-day clock with two-digit keypad entry.
//
// Each input request carries an operation in in_tuser and a keypad key in
// in_tdata. Ticks advance the clock by one second, digit operations fill a
// two-digit entry buffer, commits load the buffer into hours, minutes or
// seconds, and a clear empties the buffer.
// Every accepted request gives exactly one result on the out_ channel with
// the clock after the request and two status flags.
// The single result register shows the result in the cycle after acceptance, and
// a new request can be accepted in every cycle unless a held result is stalled.
// While the receiver stalls, the result register holds its value and
// in_tready stays high only if the waiting result is taken in that cycle.
// A synchronous reset sets the clock to 19:10:22, empties the entry buffer
// and drops out_tvalid.
module hms_clock_with_digit_entry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // key[3:0], zero fill
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hours_now, minutes_now, seconds_now,
                                  // key_accepted, entry_complete, zero fill
);
  import hmsc_pkg::*;

  logic fire;
  res_t step_res;
  res_t out_res;

  assign in_tready = !out_tvalid || out_tready;
  assign fire      = in_tvalid && in_tready;

  hmsc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .op    (in_tuser),
    .key   (in_tdata[3:0]),
    .res   (step_res)
  );

  hmsc_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire),
    .res_in  (step_res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (out_res)
  );

  assign out_tdata = {4'd0, out_res.entry_complete, out_res.key_accepted,
                      out_res.seconds, out_res.minutes, out_res.hours};

`ifndef SYNTH
  a_tick_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_tuser == OP_TICK)) |=> (out_tvalid && !out_tdata[18]))
    else $error("tick request reported an accepted key");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:12] <= LAST_SEC_MIN))
    else $error("seconds out of range");

  a_accept_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_tuser == OP_CLEAR)) |=> (out_tvalid && !out_tdata[19]))
    else $error("entry complete right after clear");
`endif

endmodule

// ===== src/hmsc_core.sv =====
// Clock and entry-buffer state with the update logic for one request.
module hmsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [2:0]          op,
  input  logic [3:0]          key,
  output hmsc_pkg::res_t      res
);
  import hmsc_pkg::*;

  logic [5:0] hours_r, hours_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [5:0] seconds_r, seconds_nxt;
  logic [3:0] dig0_r, dig0_nxt;
  logic [3:0] dig1_r, dig1_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       ok;
  logic [3:0] d;
  logic       sec_wrap;
  logic       min_wrap;
  logic [6:0] sec_sum;
  logic [6:0] min_sum;
  logic [6:0] hour_sum;
  logic [7:0] entry_val;

  assign d         = key_digit(key);
  assign entry_val = 8'(dig0_r) * 8'd10 + 8'(dig1_r);
  assign sec_wrap  = (seconds_r == LAST_SEC_MIN);
  assign min_wrap  = sec_wrap && (minutes_r == LAST_SEC_MIN);
  assign sec_sum   = 7'(seconds_r) + 7'd1;
  assign min_sum   = 7'(minutes_r) + 7'(sec_wrap);
  assign hour_sum  = 7'(hours_r) + 7'(min_wrap);

  always_comb begin
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    seconds_nxt = seconds_r;
    dig0_nxt    = dig0_r;
    dig1_nxt    = dig1_r;
    pos_nxt     = pos_r;
    ok          = 1'b0;
    case (op_t'(op))
      OP_TICK: begin
        seconds_nxt = (sec_sum >= 7'(SEC_PER_MIN)) ? 6'(sec_sum - 7'(SEC_PER_MIN))
                                                   : sec_sum[5:0];
        minutes_nxt = (min_sum >= 7'(SEC_PER_MIN)) ? 6'(min_sum - 7'(SEC_PER_MIN))
                                                   : min_sum[5:0];
        if (hour_sum >= 7'(2 * HOURS_PER_DAY)) begin
          hours_nxt = 6'(hour_sum - 7'(2 * HOURS_PER_DAY));
        end else if (hour_sum >= 7'(HOURS_PER_DAY)) begin
          hours_nxt = 6'(hour_sum - 7'(HOURS_PER_DAY));
        end else begin
          hours_nxt = hour_sum[5:0];
        end
      end
      OP_HOUR_DIGIT, OP_MS_DIGIT: begin
        if (pos_r == POS_FIRST) begin
          ok = (op_t'(op) == OP_HOUR_DIGIT) ? (d < 4'd3) : (d < 4'd6);
        end else if (pos_r == POS_SECOND) begin
          ok = (op_t'(op) == OP_HOUR_DIGIT)
             ? ((dig0_r < 4'd2) || ((dig0_r == 4'd2) && (d < 4'd4))) : 1'b1;
        end
        if (ok) begin
          if (pos_r == POS_FIRST) begin
            dig0_nxt = d;
          end else begin
            dig1_nxt = d;
          end
          pos_nxt = pos_r + 2'd1;
        end
      end
      OP_SET_HOURS: hours_nxt   = entry_val[5:0];
      OP_SET_MIN:   minutes_nxt = entry_val[5:0];
      OP_SET_SEC:   seconds_nxt = entry_val[5:0];
      OP_CLEAR: begin
        dig0_nxt = 4'd0;
        dig1_nxt = 4'd0;
        pos_nxt  = POS_FIRST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r   <= HOURS_RESET;
      minutes_r <= MINUTES_RESET;
      seconds_r <= SECONDS_RESET;
      dig0_r    <= 4'd0;
      dig1_r    <= 4'd0;
      pos_r     <= POS_FIRST;
    end else if (fire) begin
      hours_r   <= hours_nxt;
      minutes_r <= minutes_nxt;
      seconds_r <= seconds_nxt;
      dig0_r    <= dig0_nxt;
      dig1_r    <= dig1_nxt;
      pos_r     <= pos_nxt;
    end
  end

  assign res.hours          = hours_nxt;
  assign res.minutes        = minutes_nxt;
  assign res.seconds        = seconds_nxt;
  assign res.key_accepted   = ok;
  assign res.entry_complete = (pos_nxt == POS_FULL);

endmodule

// ===== src/hmsc_out_reg.sv =====
// Result register that holds one result until the receiver takes it.
module hmsc_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  hmsc_pkg::res_t res_in,
  input  logic           take,
  output logic           valid,
  output hmsc_pkg::res_t res_out
);
  import hmsc_pkg::*;

  logic valid_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the time-of-day clock with two-digit keypad entry.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hmsc_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [3:0] KEY_TO_DIGIT [14] = '{1, 2, 3, 0, 4, 5, 6, 0, 7, 8, 9, 0, 0, 0};
  localparam logic [3:0] KEY_OF_DIGIT [10] = '{3, 0, 1, 2, 4, 5, 6, 8, 9, 10};
  localparam logic [3:0] ZERO_KEYS [7] = '{3, 7, 11, 12, 13, 14, 15};
  localparam int STALL_CYCLES = 150;

  typedef struct packed {
    logic [5:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       accepted;
    logic       complete;
  } readout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [5:0] hour_now = HOURS_RESET;
  logic [5:0] minute_now = MINUTES_RESET;
  logic [5:0] second_now = SECONDS_RESET;
  logic [3:0] entry_digit [2] = '{4'd0, 4'd0};
  logic [1:0] entry_pos = POS_FIRST;

  readout_t expected_readouts[$];
  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;

  hms_clock_with_digit_entry dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic readout_t apply_request(input logic [2:0] op, input logic [3:0] key);
    readout_t r;
    logic [3:0] d;
    logic ok;
    logic is_hour;
    logic sec_wrap;
    logic min_wrap;
    ok = 1'b0;
    if (key < 4'd14) begin
      d = KEY_TO_DIGIT[key];
    end else begin
      d = 4'd0;
    end
    case (op)
      OP_TICK: begin
        sec_wrap = (second_now == LAST_SEC_MIN);
        min_wrap = sec_wrap && (minute_now == LAST_SEC_MIN);
        second_now = (second_now + 6'd1) % SEC_PER_MIN;
        minute_now = (minute_now + sec_wrap) % SEC_PER_MIN;
        hour_now = (hour_now + min_wrap) % HOURS_PER_DAY;
      end
      OP_HOUR_DIGIT, OP_MS_DIGIT: begin
        is_hour = (op == OP_HOUR_DIGIT);
        case (entry_pos)
          POS_FIRST: ok = is_hour ? (d < 3) : (d < 6);
          POS_SECOND: ok = is_hour ? (entry_digit[0] < 2 || (entry_digit[0] == 2 && d < 4)) : 1'b1;
          default: ok = 1'b0;
        endcase
        if (ok) begin
          entry_digit[entry_pos[0]] = d;
          entry_pos = entry_pos + 2'd1;
        end
      end
      OP_SET_HOURS: hour_now = 6'(entry_digit[0] * 10 + entry_digit[1]);
      OP_SET_MIN: minute_now = 6'(entry_digit[0] * 10 + entry_digit[1]);
      OP_SET_SEC: second_now = 6'(entry_digit[0] * 10 + entry_digit[1]);
      OP_CLEAR: begin
        entry_digit[0] = 4'd0;
        entry_digit[1] = 4'd0;
        entry_pos = POS_FIRST;
      end
      default: ;
    endcase
    r.hours = hour_now;
    r.minutes = minute_now;
    r.seconds = second_now;
    r.accepted = ok;
    r.complete = (entry_pos == POS_FULL);
    return r;
  endfunction

  function automatic logic [3:0] rand_key();
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [2:0] rand_op();
    return 3'($urandom_range(7));
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [3:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0000, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_readouts.push_back(apply_request(op, key));
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [3:0] key_for_digit(input int digit);
    if (digit == 0) begin
      return ZERO_KEYS[$urandom_range(6)];
    end
    return KEY_OF_DIGIT[digit];
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readouts.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual %h",
                 $realtime, out_tdata);
        error_count++;
      end else begin
        want = expected_readouts.pop_front();
        check_field("hours_now", int'(want.hours), int'(out_tdata[5:0]));
        check_field("minutes_now", int'(want.minutes), int'(out_tdata[11:6]));
        check_field("seconds_now", int'(want.seconds), int'(out_tdata[17:12]));
        check_field("key_accepted", int'(want.accepted), int'(out_tdata[18]));
        check_field("entry_complete", int'(want.complete), int'(out_tdata[19]));
      end
    end
  end

  initial begin : receiver
    int stall_left;
    int stalls_seen;
    stall_left = 0;
    stalls_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_entry_sequence();
    logic is_hour;
    int first;
    int second;
    is_hour = 1'($urandom_range(1));
    if ($urandom_range(4) != 0) send_item(OP_CLEAR, rand_key());
    if ($urandom_range(3) == 0) begin
      send_item(is_hour ? OP_HOUR_DIGIT : OP_MS_DIGIT, rand_key());
      send_item(is_hour ? OP_HOUR_DIGIT : OP_MS_DIGIT, rand_key());
    end else begin
      first = is_hour ? $urandom_range(2) : $urandom_range(5);
      second = (is_hour && first == 2) ? $urandom_range(3) : $urandom_range(9);
      send_item(is_hour ? OP_HOUR_DIGIT : OP_MS_DIGIT, key_for_digit(first));
      send_item(is_hour ? OP_HOUR_DIGIT : OP_MS_DIGIT, key_for_digit(second));
    end
    if ($urandom_range(5) == 0) send_item(3'($urandom_range(1, 2)), rand_key());
    case ($urandom_range(2))
      0: send_item(OP_SET_HOURS, rand_key());
      1: send_item(OP_SET_MIN, rand_key());
      default: send_item(OP_SET_SEC, rand_key());
    endcase
  endtask

  task automatic send_near_rollover();
    send_item(OP_CLEAR, rand_key());
    send_item(OP_MS_DIGIT, key_for_digit(5));
    send_item(OP_MS_DIGIT, key_for_digit(9));
    send_item(OP_SET_MIN, rand_key());
    send_item(OP_CLEAR, rand_key());
    send_item(OP_MS_DIGIT, key_for_digit(5));
    send_item(OP_MS_DIGIT, key_for_digit($urandom_range(5, 9)));
    send_item(OP_SET_SEC, rand_key());
    if ($urandom_range(1) == 1) begin
      send_item(OP_CLEAR, rand_key());
      send_item(OP_HOUR_DIGIT, key_for_digit(2));
      send_item(OP_HOUR_DIGIT, key_for_digit(3));
      send_item(OP_SET_HOURS, rand_key());
    end
    repeat ($urandom_range(1, 12)) send_item(OP_TICK, rand_key());
  endtask

  task automatic test_directed();
    send_item(OP_TICK, 4'd0);
    send_item(OP_CLEAR, 4'd0);
    send_item(OP_HOUR_DIGIT, 4'd2);
    send_item(OP_HOUR_DIGIT, 4'd15);
    send_item(OP_HOUR_DIGIT, 4'd14);
    send_item(OP_HOUR_DIGIT, 4'd0);
    send_item(OP_SET_HOURS, 4'd0);
    send_item(OP_CLEAR, 4'd15);
    send_item(OP_HOUR_DIGIT, 4'd1);
    send_item(OP_HOUR_DIGIT, 4'd4);
    send_item(OP_HOUR_DIGIT, 4'd2);
    send_item(OP_SET_HOURS, 4'd0);
    send_item(OP_CLEAR, 4'd0);
    send_item(OP_MS_DIGIT, 4'd6);
    send_item(OP_MS_DIGIT, 4'd5);
    send_item(OP_MS_DIGIT, 4'd10);
    send_item(OP_MS_DIGIT, 4'd13);
    send_item(OP_SET_MIN, 4'd0);
    send_item(OP_SET_SEC, 4'd0);
    send_item(OP_TICK, 4'd0);
    send_item(OP_SET_HOURS, 4'd0);
    send_item(OP_TICK, 4'd0);
    send_item(OP_UNUSED, 4'd15);
    send_item(OP_CLEAR, 4'd0);
    send_item(OP_HOUR_DIGIT, 4'd0);
    send_item(OP_HOUR_DIGIT, 4'd10);
    send_item(OP_CLEAR, 4'd0);
    send_item(OP_MS_DIGIT, 4'd4);
    send_item(OP_SET_SEC, 4'd0);
    wait_for_results();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int count);
    int start_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = items_sent;
    while (items_sent - start_count < count) begin
      case ($urandom_range(9))
        0, 1, 2: repeat ($urandom_range(1, 6)) send_item(OP_TICK, rand_key());
        3, 4, 5: send_entry_sequence();
        6: send_near_rollover();
        default: send_item(rand_op(), rand_key());
      endcase
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    repeat (30) send_item(rand_op(), rand_key());
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(13, 77, 250);
    test_random(77, 13, 250);
    test_random(0, 0, 250);
    test_backpressure();
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/hmsc_pkg.sv
src/hmsc_core.sv
src/hmsc_out_reg.sv
src/hms_clock_with_digit_entry.sv
dv/testbench.sv
